### rtl/pprx_pkg.sv
// Shared types and request codes for the ping-pong receive ring FIFO.
`default_nettype none

package pprx_pkg;

  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_IDLE = 2'd1;
  localparam logic [1:0] REQ_POP  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] pop_data;
    logic       pop_valid;
    logic       commit_done;
    logic [6:0] committed_count;
    logic [6:0] dropped_count;
    logic [8:0] fifo_level;
  } out_t;

endpackage

`default_nettype wire

### rtl/pprx_in_if.sv
// Input channel interface: request transactions into the receive buffer.
`default_nettype none

interface pprx_in_if;
  logic            valid;
  logic            ready;
  pprx_pkg::in_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/pprx_out_if.sv
// Output channel interface: one result transaction per accepted request.
`default_nettype none

interface pprx_out_if;
  logic            valid;
  logic            ready;
  pprx_pkg::out_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/pingpong_rx_ring_fifo_core.sv
// Ping-pong receive staging store with a circular byte FIFO behind it.
`default_nettype none

// Channel   Dir  Payload                                         Transaction
// -------   ---  ----------------------------------------------  ---------------------------
// in_i      in   req_type, rx_byte                               valid && ready
// out_o     out  pop_data, pop_valid, commit_done, committed_    valid && ready
//                count, dropped_count, fifo_level
//
// One request is in flight at a time; in_i.ready is high only in the idle state.
// A received byte without commit passes through the emit state, a pop through the
// pop and emit states, and a commit through the copy and emit states, also when
// nothing is copied: the copy moves one byte per cycle through the staging read
// port and the FIFO write port, pipelined by one register, and then drains.
// The result register decouples the sides: a new request is taken while the
// previous result still waits on out_o.ready; a second finished result waits in
// the emit state until the output register frees up. Reset is asynchronous,
// active low, and needs no clearing pass: both stores are only read where written.

module pingpong_rx_ring_fifo_core #(
  parameter int RX_LEN   = 64,
  parameter int RING_LEN = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pprx_in_if.sink    in_i,
  pprx_out_if.source out_o
);
  import pprx_pkg::*;

  localparam int SAW = $clog2(2 * RX_LEN);     // staging address width
  localparam int SCW = $clog2(RX_LEN + 1);     // staged count width
  localparam int PW  = $clog2(RING_LEN);       // FIFO pointer width
  localparam int CW  = $clog2(RING_LEN + 1);   // fill count width
  localparam int MW  = (SCW > CW) ? SCW : CW;  // width for space arithmetic

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_POP,
    ST_EMIT
  } state_e;

  // Storage
  logic [7:0] stg_mem [2*RX_LEN];
  logic [7:0] fifo_mem [RING_LEN];

  // Control state
  state_e          state_q;
  logic            half_q;
  logic [SCW-1:0]  staged_q;
  logic [PW-1:0]   wr_pos_q;
  logic [PW-1:0]   rd_pos_q;
  logic [CW-1:0]   fill_q;
  logic            cp_half_q;
  logic [SCW-1:0]  cp_n_q;
  logic [SCW-1:0]  cp_idx_q;
  logic            wr_pend_q;
  out_t            res_q;
  logic            out_vld_q;
  out_t            out_q;

  // Memory ports
  logic            stg_we;
  logic [SAW-1:0]  stg_waddr;
  logic [SAW-1:0]  stg_raddr;
  logic [7:0]      stg_rdata_q;
  logic            fifo_we;
  logic [7:0]      fifo_rdata_q;

  // Request decode
  logic            accept;
  logic [1:0]      req;
  logic [SCW-1:0]  cnt_after;
  logic            do_commit;
  logic [MW-1:0]   free_sp;
  logic [MW-1:0]   n_calc;
  logic [MW-1:0]   drop_calc;
  logic            pop_hit;
  out_t            res_new;
  logic            cp_issue;
  logic            out_load;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign req         = in_i.data.req_type;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // Work out the staged count after this byte and how much of the half fits.
  always_comb begin
    cnt_after = staged_q;
    do_commit = 1'b0;
    stg_we    = 1'b0;
    unique case (req)
      REQ_BYTE: begin
        if (staged_q < SCW'(RX_LEN)) begin
          cnt_after = staged_q + SCW'(1);
          stg_we    = accept;
        end
        do_commit = (cnt_after >= SCW'(RX_LEN));
      end
      REQ_IDLE: do_commit = 1'b1;
      default:  do_commit = 1'b0;
    endcase
    free_sp   = MW'(RING_LEN) - MW'(fill_q);
    n_calc    = (MW'(cnt_after) < free_sp) ? MW'(cnt_after) : free_sp;
    drop_calc = MW'(cnt_after) - n_calc;
    pop_hit   = (req == REQ_POP) && (fill_q != '0);

    // Result as known at accept time; pop data follows from the FIFO read.
    res_new            = '0;
    res_new.fifo_level = 9'(fill_q);
    if (do_commit) begin
      res_new.commit_done     = 1'b1;
      res_new.committed_count = 7'(n_calc);
      res_new.dropped_count   = 7'(drop_calc);
      res_new.fifo_level      = 9'(fill_q + CW'(n_calc));
    end else if (pop_hit) begin
      res_new.pop_valid  = 1'b1;
      res_new.fifo_level = 9'(fill_q - CW'(1));
    end
  end

  assign stg_waddr = half_q ? (SAW'(RX_LEN) + SAW'(staged_q)) : SAW'(staged_q);
  assign stg_raddr = cp_half_q ? (SAW'(RX_LEN) + SAW'(cp_idx_q)) : SAW'(cp_idx_q);
  assign cp_issue  = (state_q == ST_COPY) && (cp_idx_q < cp_n_q);
  assign fifo_we   = (state_q == ST_COPY) && wr_pend_q;
  assign out_load  = (state_q == ST_EMIT) && (!out_vld_q || out_o.ready);

  // Staging store: byte writes on accept, reads for the commit copy.
  always_ff @(posedge clk_i) begin
    if (stg_we) begin
      stg_mem[stg_waddr] <= in_i.data.rx_byte;
    end
    stg_rdata_q <= stg_mem[stg_raddr];
  end

  // FIFO store: copy writes, pop reads at the current read pointer.
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[wr_pos_q] <= stg_rdata_q;
    end
    fifo_rdata_q <= fifo_mem[rd_pos_q];
  end

  // Sequencer with the result and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      half_q    <= 1'b0;
      staged_q  <= '0;
      wr_pos_q  <= '0;
      rd_pos_q  <= '0;
      fill_q    <= '0;
      cp_half_q <= 1'b0;
      cp_n_q    <= '0;
      cp_idx_q  <= '0;
      wr_pend_q <= 1'b0;
      res_q     <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      // Load a finished result, else drop the output once the sink takes it.
      if (out_load) begin
        out_q     <= res_q;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            res_q <= res_new;
            if (do_commit) begin
              // Commit the active half: toggle, clip to free space, start copy.
              staged_q  <= '0;
              half_q    <= ~half_q;
              cp_half_q <= half_q;
              cp_n_q    <= SCW'(n_calc);
              cp_idx_q  <= '0;
              wr_pend_q <= 1'b0;
              fill_q    <= fill_q + CW'(n_calc);
              state_q   <= ST_COPY;
            end else if (pop_hit) begin
              // FIFO read is already under way at rd_pos_q.
              fill_q   <= fill_q - CW'(1);
              rd_pos_q <= (rd_pos_q == PW'(RING_LEN - 1)) ? '0 : rd_pos_q + PW'(1);
              state_q  <= ST_POP;
            end else begin
              staged_q <= cnt_after;
              state_q  <= ST_EMIT;
            end
          end
        end

        ST_COPY: begin
          // Issue a staging read each cycle, write it to the FIFO in the following cycle.
          wr_pend_q <= cp_issue;
          if (cp_issue) begin
            cp_idx_q <= cp_idx_q + SCW'(1);
          end
          if (wr_pend_q) begin
            wr_pos_q <= (wr_pos_q == PW'(RING_LEN - 1)) ? '0 : wr_pos_q + PW'(1);
          end
          if (!cp_issue && !wr_pend_q) begin
            state_q <= ST_EMIT;
          end
        end

        ST_POP: begin
          res_q.pop_data <= fifo_rdata_q;
          state_q        <= ST_EMIT;
        end

        ST_EMIT: begin
          // Hold the result until the output register is free.
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Fill count never exceeds the ring size.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(RING_LEN))
    else $error("fill count above ring size");

  // A half at capacity is always committed within the same request.
  a_staged_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (staged_q < SCW'(RX_LEN)))
    else $error("staged count reached capacity outside a commit");

  // The copy never reads past the clipped byte count.
  a_copy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> (cp_idx_q <= cp_n_q))
    else $error("copy index past commit count");

  // One request in flight: ready drops right after an accepted transaction.
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("request accepted while another is in flight");

  // A pop read only follows an accepted pop transaction.
  a_pop_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> ($past(accept) && $past(req) == REQ_POP))
    else $error("pop state without a pop request");

endmodule

`default_nettype wire

### test/pingpong_rx_ring_fifo_core_checker.sv
// Scoreboard for the ping-pong receive ring FIFO: predicts every result and compares it.
`timescale 1ns / 1ps

module pingpong_rx_ring_fifo_core_checker #(
  parameter int RX_LEN   = 64,
  parameter int RING_LEN = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  pprx_pkg::in_t    in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  pprx_pkg::out_t   out_data_i,
  output int               fail_cnt_o,
  output int               pending_o
);

  logic [7:0]  stage_mem [2*RX_LEN];
  logic [7:0]  ring_mem  [RING_LEN];
  bit          half_sel;
  int unsigned staged_n;
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  int unsigned ring_level;

  pprx_pkg::out_t results_due[$];

  int n_checked, n_pops, n_empty_pops, n_commits, n_half_fills;
  int n_empty_commits, n_clipped, n_dropped_bytes, peak_level;

  // Copy the active half into the ring, clipped to the free space, then toggle halves.
  function automatic void commit_half(output int unsigned moved, output int unsigned dropped);
    int unsigned space;
    int unsigned base;
    int unsigned i;
    space   = RING_LEN - ring_level;
    moved   = (staged_n < space) ? staged_n : space;
    dropped = staged_n - moved;
    base    = half_sel * RX_LEN;
    for (i = 0; i < moved; i++) begin
      ring_mem[wr_ptr] = stage_mem[base + i];
      wr_ptr = (wr_ptr + 1) % RING_LEN;
    end
    ring_level += moved;
    staged_n = 0;
    half_sel = ~half_sel;
    n_commits++;
    if (moved + dropped == 0) n_empty_commits++;
    if (dropped != 0) begin
      n_clipped++;
      n_dropped_bytes += dropped;
    end
  endfunction

  function automatic pprx_pkg::out_t predict_result(pprx_pkg::in_t req);
    pprx_pkg::out_t res;
    int unsigned    moved;
    int unsigned    dropped;
    bit             do_commit;
    res = '0;
    do_commit = 1'b0;
    case (req.req_type)
      pprx_pkg::REQ_BYTE: begin
        stage_mem[half_sel * RX_LEN + staged_n] = req.rx_byte;
        staged_n++;
        if (staged_n == RX_LEN) begin
          n_half_fills++;
          do_commit = 1'b1;
        end
      end
      pprx_pkg::REQ_IDLE: begin
        do_commit = 1'b1;
      end
      pprx_pkg::REQ_POP: begin
        if (ring_level != 0) begin
          res.pop_data  = ring_mem[rd_ptr];
          res.pop_valid = 1'b1;
          rd_ptr = (rd_ptr + 1) % RING_LEN;
          ring_level--;
          n_pops++;
        end else begin
          n_empty_pops++;
        end
      end
      default: ;
    endcase
    if (do_commit) begin
      commit_half(moved, dropped);
      res.commit_done     = 1'b1;
      res.committed_count = 7'(moved);
      res.dropped_count   = 7'(dropped);
    end
    res.fifo_level = 9'(ring_level);
    if (ring_level > peak_level) peak_level = ring_level;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [8:0] want_v,
                             input logic [8:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pprx_pkg::out_t want;
    if (!rst_ni) begin
      half_sel   = 1'b0;
      staged_n   = 0;
      wr_ptr     = 0;
      rd_ptr     = 0;
      ring_level = 0;
      results_due.delete();
      pending_o  = 0;
    end else begin
      // Retire the result first: it always belongs to an earlier request.
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("result with no request outstanding: %p", out_data_i);
          fail_cnt_o++;
        end else begin
          want = results_due.pop_front();
          check_field("pop_data", 9'(want.pop_data), 9'(out_data_i.pop_data));
          check_field("pop_valid", 9'(want.pop_valid), 9'(out_data_i.pop_valid));
          check_field("commit_done", 9'(want.commit_done), 9'(out_data_i.commit_done));
          check_field("committed_count", 9'(want.committed_count),
                      9'(out_data_i.committed_count));
          check_field("dropped_count", 9'(want.dropped_count),
                      9'(out_data_i.dropped_count));
          check_field("fifo_level", want.fifo_level, out_data_i.fifo_level);
          n_checked++;
        end
      end
      if (in_valid_i && in_ready_i) results_due.push_back(predict_result(in_data_i));
      pending_o = results_due.size();
    end
  end

  task automatic report_coverage();
    $display("checked %0d results: %0d bytes popped, %0d pops on an empty ring, peak level %0d",
             n_checked, n_pops, n_empty_pops, peak_level);
    $display("%0d commits: %0d on a full half, %0d with nothing staged, %0d clipped (%0d bytes lost)",
             n_commits, n_half_fills, n_empty_commits, n_clipped, n_dropped_bytes);
  endtask

endmodule

### test/pingpong_rx_ring_fifo_core_tb.sv
// Testbench top for the ping-pong receive ring FIFO: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module pingpong_rx_ring_fifo_core_tb;

  import pprx_pkg::*;

  localparam int RX_LEN      = 64;
  localparam int RING_LEN    = 256;
  localparam int N_REQUESTS  = 1200;  // counted requests; the spare code is not counted
  localparam int CALM_AFTER  = 1100;  // no idling on either side past this point
  localparam int FILL_SPAN   = 350;   // requests per ring filling phase
  localparam int DRAIN_SPAN  = 300;   // requests per ring draining phase
  localparam int HOLD_AT     = 150;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;  // limit on the quiet count (no transaction on either side) before giving up
  localparam int DRAIN_WAIT  = 80;    // settling wait after the last result; the longest commit copies RX_LEN bytes

  // The package names three request codes; the block answers the fourth with a result but changes no state.
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bit calm;
  bit tx_gaps_on;
  int requests_sent;
  int results_seen;
  int quiet_cycles;
  int fail_cnt;
  int pending;

  pprx_in_if  in_ch ();
  pprx_out_if out_ch ();

  pingpong_rx_ring_fifo_core #(
    .RX_LEN   (RX_LEN),
    .RING_LEN (RING_LEN)
  ) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  pingpong_rx_ring_fifo_core_checker #(
    .RX_LEN   (RX_LEN),
    .RING_LEN (RING_LEN)
  ) u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold reset low from the start, release it on a falling edge, never assert it again.
  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Request side. Every task is entered and left on a falling edge, so each
  // input changes away from the sampling edge.
  // ---------------------------------------------------------------------------

  // Drop valid for a gap set by the argument n. Called only on a falling edge
  // where valid was not already written, so each step sees a single update of valid.
  task automatic idle_gap(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Offer one request, possibly after a random gap, and hold it until taken.
  task automatic offer(input logic [1:0] kind, input logic [7:0] value);
    pprx_pkg::in_t item;
    if (!calm && tx_gaps_on && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 13));
    item.req_type = kind;
    item.rx_byte  = value;
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (kind != REQ_SPARE) begin
      requests_sent++;
      // Reshuffle the sender's idling every hundred requests, leaving some
      // stretches with no gaps at all.
      if (requests_sent % 100 == 0) tx_gaps_on = ($urandom_range(0, 2) != 0);
      if (requests_sent >= CALM_AFTER) calm = 1'b1;
    end
  endtask

  // Stream len received bytes, then optionally close the burst with a line idle.
  task automatic byte_burst(input int len, input bit close);
    for (int i = 0; i < len; i++) offer(REQ_BYTE, 8'($urandom_range(0, 255)));
    if (close) offer(REQ_IDLE, 8'($urandom_range(0, 255)));
  endtask

  task automatic pop_run(input int len);
    for (int i = 0; i < len; i++) offer(REQ_POP, 8'($urandom_range(0, 255)));
  endtask

  // Any code, the spare one included, with any byte.
  task automatic noise(input int len);
    for (int i = 0; i < len; i++)
      offer(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    bit filling;
    int phase_start;
    int r;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    tx_gaps_on  = 1'b1;
    wait (rst_n);
    @(negedge clk);

    // Directed opening: pop and idle on an empty block, the byte extremes,
    // an idle commit and its read-back in order, the spare code, and an idle
    // right after a commit, which commits an empty half.
    offer(REQ_POP,   8'hFF);
    offer(REQ_IDLE,  8'h00);
    offer(REQ_BYTE,  8'h00);
    offer(REQ_BYTE,  8'hFF);
    offer(REQ_BYTE,  8'hA5);
    offer(REQ_BYTE,  8'h5A);
    offer(REQ_IDLE,  8'hFF);
    offer(REQ_SPARE, 8'hFF);
    pop_run(5);
    offer(REQ_BYTE,  8'h01);
    offer(REQ_BYTE,  8'h80);
    offer(REQ_IDLE,  8'h00);
    offer(REQ_IDLE,  8'h00);
    offer(REQ_SPARE, 8'h00);
    pop_run(3);

    // Random part: alternate phases that fill the ring past its capacity,
    // so commits get clipped, with phases that drain it below empty.
    filling     = 1'b1;
    phase_start = requests_sent;
    while (requests_sent < N_REQUESTS) begin
      if (filling) begin
        r = $urandom_range(0, 15);
        if (r < 10) begin
          // Mostly partial bursts; some exactly one half, some over one half, up to just over two.
          case ($urandom_range(0, 7))
            0:       byte_burst(RX_LEN, $urandom_range(0, 3) != 0);
            1:       byte_burst($urandom_range(RX_LEN + 1, 2 * RX_LEN + 12),
                                $urandom_range(0, 3) != 0);
            default: byte_burst($urandom_range(1, RX_LEN - 1), $urandom_range(0, 3) != 0);
          endcase
        end else if (r < 13) begin
          pop_run($urandom_range(1, 4));
        end else if (r < 15) begin
          noise($urandom_range(1, 3));
        end else begin
          // Back-to-back idles: the second one commits nothing.
          offer(REQ_IDLE, 8'($urandom_range(0, 255)));
          offer(REQ_IDLE, 8'($urandom_range(0, 255)));
        end
        if (requests_sent - phase_start >= FILL_SPAN) begin
          filling     = 1'b0;
          phase_start = requests_sent;
        end
      end else begin
        r = $urandom_range(0, 15);
        if (r < 11)      pop_run($urandom_range(1, 40));
        else if (r < 14) byte_burst($urandom_range(1, 20), 1'b1);
        else             noise($urandom_range(1, 3));
        if (requests_sent - phase_start >= DRAIN_SPAN) begin
          filling     = 1'b1;
          phase_start = requests_sent;
        end
      end
    end
    in_ch.valid <= 1'b0;

    // Wait for every outstanding result, then let the block settle.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    u_chk.report_coverage();
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side. Stall in random bursts whose density is redrawn from three
  // levels during the run, hold off once for a long stretch so the block backs
  // up into its input, and stop stalling once the run turns calm.
  // ---------------------------------------------------------------------------
  initial begin
    int  stall_left;
    int  busy_pct;
    int  cyc;
    bit  held;
    stall_left = 0;
    busy_pct   = 0;
    cyc        = 0;
    held       = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       busy_pct = 0;
          1:       busy_pct = 15;
          default: busy_pct = 40;
        endcase
      end
      cyc++;
      if (!held && results_seen >= HOLD_AT) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left == 0 && !calm && busy_pct != 0 && $urandom_range(0, 99) < busy_pct)
        stall_left = $urandom_range(1, 13);
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Count results and watch for a stall: end the run when the quiet count of
  // cycles with no transaction on either channel reaches QUIET_LIMIT.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_ch.valid && out_ch.ready) results_seen <= results_seen + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
